// ===== src/pdcm_pkg.sv =====
package pdcm_pkg;

  localparam int DUTY_W    = 14;
  localparam int TIMEOUT_W = 20;

  localparam logic [DUTY_W-1:0]    FULL_SCALE    = 14'd10000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd7000;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_IDLE_TIMEOUT = 1'b0;

  typedef logic [DUTY_W-1:0] duty_t;

endpackage

// ===== src/pdcm_regs.sv =====
module pdcm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [pdcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [pdcm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [pdcm_pkg::TIMEOUT_W-1:0] idle_timeout_ticks
);
  import pdcm_pkg::*;

  logic wr_en;
  logic sel_timeout;

  assign pready      = 1'b1;
  assign sel_timeout = (paddr[PADDR_W-1:2] == REG_IDLE_TIMEOUT);
  assign wr_en       = psel && penable && pwrite && pready && sel_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      idle_timeout_ticks <= pwdata[TIMEOUT_W-1:0];
    end
  end

  always_comb begin
    if (sel_timeout) begin
      prdata = PDATA_W'(idle_timeout_ticks);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== src/pdcm_ratio.sv =====
module pdcm_ratio #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] high,
  input  logic [COUNT_WIDTH-1:0] period,
  output logic                   done,
  output pdcm_pkg::duty_t        duty
);
  import pdcm_pkg::*;

  localparam int W = COUNT_WIDTH + DUTY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [3:0] LAST_BIT = 4'(DUTY_W - 1);

  logic [2:0]             state;
  logic [3:0]             k;
  logic [W-1:0]           acc;
  logic [COUNT_WIDTH-1:0] rem;
  logic [DUTY_W-1:0]      num_lo;
  logic [DUTY_W-1:0]      quo;
  logic [COUNT_WIDTH-1:0] op_high;
  logic [COUNT_WIDTH-1:0] op_period;

  // shared add/subtract unit
  logic [W-1:0] op_a;
  logic [W-1:0] op_b;
  logic         sub;
  logic [W:0]   sum;
  logic         ge;

  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b1;
    case (state)
      S_CMP: begin
        op_a = W'(op_high);
        op_b = W'(op_period);
      end
      S_MUL: begin
        op_a = {acc[W-2:0], 1'b0};
        op_b = FULL_SCALE[k] ? W'(op_high) : '0;
        sub  = 1'b0;
      end
      S_DIV: begin
        op_a = W'({rem, num_lo[DUTY_W-1]});
        op_b = W'(op_period);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (W+1)'(sub);
  assign ge  = sum[W];

  assign done = (state == S_FIN);
  assign duty = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          k <= LAST_BIT;
          if (ge) begin
            state <= S_FIN;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (k == '0) begin
            k     <= LAST_BIT;
            state <= S_DIV;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_DIV: begin
          if (k == '0) begin
            state <= S_FIN;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op_high   <= high;
          op_period <= period;
        end
      end
      S_CMP: begin
        acc <= '0;
        // high >= period clamps to full scale
        if (ge) begin
          quo <= FULL_SCALE;
        end
      end
      S_MUL: begin
        acc <= sum[W-1:0];
        if (k == '0) begin
          rem    <= sum[W-1:DUTY_W];
          num_lo <= sum[DUTY_W-1:0];
        end
      end
      S_DIV: begin
        rem    <= ge ? sum[COUNT_WIDTH-1:0] : {rem[COUNT_WIDTH-2:0], num_lo[DUTY_W-1]};
        num_lo <= {num_lo[DUTY_W-2:0], 1'b0};
        quo    <= {quo[DUTY_W-2:0], ge};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

// ===== src/pwm_duty_cycle_meter.sv =====
// PWM duty-cycle meter: one word per timer tick, one result word per tick.
// Tick without a measurement: accept moves to the output state, which registers the result, then back to idle.
// Falling edge: the result is set by the shared adder of the ratio unit
// (1 compare, 14 multiply, 14 divide steps); high >= period clamps to full scale after the compare.
// in_ready is low while a tick is in work; a stalled output holds the block in its output state.
// Synchronous active-high reset clears counters, duty and level, sets the timeout to 7000.
module pwm_duty_cycle_meter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pin_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pdcm_pkg::DUTY_W-1:0]   duty_hundredths,
  output logic                          new_measurement,
  output logic                          stuck_flag,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [pdcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [pdcm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pdcm_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [TIMEOUT_W-1:0]   idle_timeout_ticks;
  logic [1:0]             state;
  logic                   previous_level;
  logic [COUNT_WIDTH-1:0] high_ticks;
  logic [COUNT_WIDTH-1:0] period_ticks;
  logic [COUNT_WIDTH-1:0] idle_ticks;
  duty_t                  duty_value;
  logic                   fresh;
  logic                   stuck;

  logic [COUNT_WIDTH-1:0] high_next;
  logic [COUNT_WIDTH-1:0] period_next;
  logic [COUNT_WIDTH-1:0] idle_next;
  logic [COUNT_WIDTH-1:0] high_inc;
  logic [COUNT_WIDTH-1:0] period_inc;
  logic [COUNT_WIDTH-1:0] idle_inc;
  logic                   rising;
  logic                   falling;
  logic                   timeout;
  logic                   measure;
  logic                   accept;
  logic                   out_free;
  logic                   ratio_done;
  duty_t                  ratio_duty;

  pdcm_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .idle_timeout_ticks (idle_timeout_ticks)
  );

  pdcm_ratio #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ratio (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && measure),
    .high   (high_inc),
    .period (period_inc),
    .done   (ratio_done),
    .duty   (ratio_duty)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign high_inc   = (&high_ticks)   ? high_ticks   : high_ticks + COUNT_WIDTH'(1);
  assign period_inc = (&period_ticks) ? period_ticks : period_ticks + COUNT_WIDTH'(1);
  assign idle_inc   = (&idle_ticks)   ? idle_ticks   : idle_ticks + COUNT_WIDTH'(1);

  assign rising  = pin_level && !previous_level;
  assign falling = !pin_level && previous_level;
  assign measure = falling && (period_inc != '0);

  always_comb begin
    high_next   = rising  ? '0 : high_inc;
    period_next = falling ? '0 : period_inc;
    idle_next   = (rising || falling) ? '0 : idle_inc;
  end

  assign timeout = CMP_W'(idle_next) > CMP_W'(idle_timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      previous_level <= 1'b0;
      high_ticks     <= '0;
      period_ticks   <= '0;
      idle_ticks     <= '0;
      duty_value     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            previous_level <= pin_level;
            high_ticks     <= high_next;
            period_ticks   <= period_next;
            idle_ticks     <= idle_next;
            if (timeout) begin
              duty_value <= pin_level ? FULL_SCALE : '0;
            end
            state <= measure ? S_CALC : S_OUT;
          end
        end
        S_CALC: begin
          if (ratio_done) begin
            duty_value <= ratio_duty;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fresh <= measure;
      stuck <= timeout;
    end
    if ((state == S_OUT) && out_free) begin
      duty_hundredths <= duty_value;
      new_measurement <= fresh;
      stuck_flag      <= stuck;
    end
  end

endmodule
